### src/stt_pkg.sv
// shared types and constants for the soft timer table
`timescale 1ns / 1ps

package stt_pkg;

  localparam int NUM_SLOTS_DEF = 16;

  localparam logic [7:0] SCAN_PERIOD_RESET = 8'd20;

  // action codes
  localparam logic [2:0] ACT_ADD     = 3'd0;
  localparam logic [2:0] ACT_DELETE  = 3'd1;
  localparam logic [2:0] ACT_ENABLE  = 3'd2;
  localparam logic [2:0] ACT_DISABLE = 3'd3;
  localparam logic [2:0] ACT_ONESHOT = 3'd4;
  localparam logic [2:0] ACT_TICK    = 3'd5;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  // one slot as kept in the table memory
  typedef struct packed {
    logic        enabled;
    logic        single;
    logic        notify;
    logic [15:0] remaining;
    logic [15:0] period;
  } stt_entry_t;

  localparam int ENTRY_W = $bits(stt_entry_t);

endpackage

### src/stt_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module stt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### src/soft_timer_table.sv
// soft timer table top level: slot table, prescaler and scan sequencer
`timescale 1ns / 1ps

// Table of NUM_SLOTS software timers driven by action beats on the in_ stream.
// Each beat gives one or more result beats on the out_ stream; out_tlast marks
// the final one. An add takes the lowest free slot, and delete, enable, disable
// and set one-shot address a slot by id and fail on a bad id or a free slot.
// A tick decrements the prescaler; when it hits zero it reloads from the
// scan_period register (cfg_ port) and every enabled slot is decremented once.
// Each notifying slot that reaches zero gives one expiry beat (out_tuser high),
// in ascending slot order; a tick with no expiry gives a single ok beat.
// Slot contents live in one table memory with a registered read;
// the valid marks are flip-flops cleared by reset, so the memory needs no
// clearing pass and an item may follow reset at once.
// Steps: add, delete, unknown actions and ticks without a scan load their
// result straight from the execute state; enable, disable and set one-shot
// read the slot, then modify and write it back (no read when the id or the
// slot is bad); a scanning tick walks all NUM_SLOTS slots through the single
// table memory, which reads and writes back one slot per cycle while no older
// expiry waits for the output. A stalled out_ side holds the sequencer. One
// item is in work at a time; the next beat is accepted once the result of the
// current one sits in the output register, even if that beat has not been taken yet.
module soft_timer_table
  import stt_pkg::*;
#(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // action beats
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,  // slot_id[3:0], timeout_ticks[19:4], single_flag[20],
                                 // notify_flag[21], zero pad[23:22]
  input  logic [2:0]  in_tuser,  // action[2:0]
  // result beats
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata, // status[0], result_id[4:1], zero pad[7:5]
  output logic        out_tuser, // expired[0]
  output logic        out_tlast,
  // scan_period register
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

  // sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EXEC = 3'd1;
  localparam logic [2:0] ST_RMW  = 3'd2;
  localparam logic [2:0] ST_SCAN = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0]           state_r, state_nxt;
  logic [NUM_SLOTS-1:0] valid_r, valid_nxt;
  logic [7:0]           scan_period_r;
  logic [7:0]           presc_r, presc_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic                 pend_v_r, pend_v_nxt;
  logic [3:0]           pend_id_r, pend_id_nxt;

  // latched action beat
  logic [2:0]  act_r;
  logic [3:0]  id_r;
  logic [15:0] to_r;
  logic        os_r;
  logic        nf_r;

  // output register
  logic       out_valid_r;
  logic       out_status_r;
  logic [3:0] out_id_r;
  logic       out_exp_r;
  logic       out_last_r;

  logic       push;
  logic       push_status;
  logic [3:0] push_id;
  logic       push_exp;
  logic       push_last;
  logic       out_free;

  // table memory port
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  stt_entry_t       mem_wdata;
  logic             mem_re;
  logic [IDX_W-1:0] mem_raddr;
  logic [ENTRY_W-1:0] mem_rdata;
  stt_entry_t       rd_entry;

  logic             in_beat;
  logic             id_ok;
  logic [IDX_W-1:0] id_idx;
  logic [IDX_W-1:0] free_idx;
  logic             all_valid;
  logic [7:0]       presc_dec;
  logic [IDX_W+3:0] free_ext;
  logic [IDX_W+3:0] idx_ext;

  // scan datapath
  logic        scan_active;
  logic [15:0] scan_dec;
  logic        scan_hit;
  logic        scan_emit;
  stt_entry_t  scan_entry;
  stt_entry_t  rmw_entry;

  assign in_tready = (state_r == ST_IDLE);
  assign in_beat   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_tready;

  assign id_ok     = (32'(id_r) < NUM_SLOTS);
  assign id_idx    = IDX_W'(id_r);
  assign all_valid = &valid_r;
  assign presc_dec = (presc_r != 8'd0) ? presc_r - 8'd1 : 8'd0;
  assign free_ext  = (IDX_W + 4)'(free_idx);
  assign idx_ext   = (IDX_W + 4)'(idx_r);
  assign rd_entry  = stt_entry_t'(mem_rdata);

  // lowest free slot
  always_comb begin
    free_idx = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_idx = IDX_W'(i);
      end
    end
  end

  // one slot of the scan: decrement, detect expiry, reload or stop
  always_comb begin
    scan_active = valid_r[idx_r] && rd_entry.enabled;
    scan_dec    = rd_entry.remaining - 16'd1;
    scan_hit    = scan_active && (scan_dec == 16'd0);
    scan_emit   = scan_hit && rd_entry.notify;
    scan_entry  = rd_entry;
    scan_entry.remaining = scan_dec;
    if (scan_hit) begin
      if (rd_entry.single) begin
        scan_entry.enabled = 1'b0;
      end else begin
        scan_entry.remaining = rd_entry.period;
      end
    end
  end

  // enable, disable and set one-shot on a slot read back from the table
  always_comb begin
    rmw_entry = rd_entry;
    case (act_r)
      ACT_ENABLE: begin
        rmw_entry.enabled   = 1'b1;
        rmw_entry.remaining = to_r;
        rmw_entry.period    = to_r;
      end
      ACT_DISABLE: begin
        rmw_entry.enabled = 1'b0;
      end
      default: begin
        rmw_entry.single = os_r;
      end
    endcase
  end

  always_comb begin
    state_nxt   = state_r;
    valid_nxt   = valid_r;
    presc_nxt   = presc_r;
    idx_nxt     = idx_r;
    pend_v_nxt  = pend_v_r;
    pend_id_nxt = pend_id_r;
    push        = 1'b0;
    push_status = STATUS_OK;
    push_id     = 4'd0;
    push_exp    = 1'b0;
    push_last   = 1'b1;
    mem_we      = 1'b0;
    mem_waddr   = idx_r;
    mem_wdata   = rd_entry;
    mem_re      = 1'b0;
    mem_raddr   = idx_r;

    case (state_r)
      ST_IDLE: begin
        if (in_beat) begin
          state_nxt = ST_EXEC;
        end
      end

      ST_EXEC: begin
        case (act_r)
          ACT_ADD: begin
            if (out_free) begin
              push      = 1'b1;
              state_nxt = ST_IDLE;
              if (all_valid) begin
                push_status = STATUS_FAIL;
              end else begin
                mem_we              = 1'b1;
                mem_waddr           = free_idx;
                mem_wdata.enabled   = 1'b0;
                mem_wdata.single    = os_r;
                mem_wdata.notify    = nf_r;
                mem_wdata.remaining = to_r;
                mem_wdata.period    = to_r;
                valid_nxt[free_idx] = 1'b1;
                push_id             = free_ext[3:0];
              end
            end
          end
          ACT_DELETE: begin
            if (out_free) begin
              push      = 1'b1;
              state_nxt = ST_IDLE;
              if (!id_ok || !valid_r[id_idx]) begin
                push_status = STATUS_FAIL;
              end else begin
                valid_nxt[id_idx] = 1'b0;
              end
            end
          end
          ACT_ENABLE, ACT_DISABLE, ACT_ONESHOT: begin
            if (!id_ok || !valid_r[id_idx]) begin
              if (out_free) begin
                push        = 1'b1;
                push_status = STATUS_FAIL;
                state_nxt   = ST_IDLE;
              end
            end else begin
              mem_re    = 1'b1;
              mem_raddr = id_idx;
              state_nxt = ST_RMW;
            end
          end
          ACT_TICK: begin
            if (out_free) begin
              if (presc_dec == 8'd0) begin
                presc_nxt = scan_period_r;
                mem_re    = 1'b1;
                mem_raddr = '0;
                idx_nxt   = '0;
                state_nxt = ST_SCAN;
              end else begin
                presc_nxt = presc_dec;
                push      = 1'b1;
                state_nxt = ST_IDLE;
              end
            end
          end
          default: begin
            if (out_free) begin
              push        = 1'b1;
              push_status = STATUS_FAIL;
              state_nxt   = ST_IDLE;
            end
          end
        endcase
      end

      ST_RMW: begin
        if (out_free) begin
          mem_we    = 1'b1;
          mem_waddr = id_idx;
          mem_wdata = rmw_entry;
          push      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      ST_SCAN: begin
        // hold the slot when it expires while an older expiry still waits for the output
        if (!(scan_emit && pend_v_r && !out_free)) begin
          mem_we    = scan_active;
          mem_waddr = idx_r;
          mem_wdata = scan_entry;
          if (scan_emit) begin
            if (pend_v_r) begin
              push      = 1'b1;
              push_id   = pend_id_r;
              push_exp  = 1'b1;
              push_last = 1'b0;
            end
            pend_v_nxt  = 1'b1;
            pend_id_nxt = idx_ext[3:0];
          end
          if (idx_r == LAST_IDX) begin
            state_nxt = ST_DONE;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            mem_re    = 1'b1;
            mem_raddr = idx_r + 1'b1;
          end
        end
      end

      ST_DONE: begin
        if (out_free) begin
          push       = 1'b1;
          push_id    = pend_v_r ? pend_id_r : 4'd0;
          push_exp   = pend_v_r;
          pend_v_nxt = 1'b0;
          state_nxt  = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      valid_r       <= '0;
      scan_period_r <= SCAN_PERIOD_RESET;
      presc_r       <= SCAN_PERIOD_RESET;
      idx_r         <= '0;
      pend_v_r      <= 1'b0;
      pend_id_r     <= 4'd0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      valid_r   <= valid_nxt;
      presc_r   <= presc_nxt;
      idx_r     <= idx_nxt;
      pend_v_r  <= pend_v_nxt;
      pend_id_r <= pend_id_nxt;
      if (cfg_valid && cfg_ready) begin
        scan_period_r <= cfg_data;
      end
      if (push) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_beat) begin
      act_r <= in_tuser;
      id_r  <= in_tdata[3:0];
      to_r  <= in_tdata[19:4];
      os_r  <= in_tdata[20];
      nf_r  <= in_tdata[21];
    end
    if (push) begin
      out_status_r <= push_status;
      out_id_r     <= push_id;
      out_exp_r    <= push_exp;
      out_last_r   <= push_last;
    end
  end

  stt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_SLOTS),
    .AW    (IDX_W)
  ) u_table (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (ENTRY_W'(mem_wdata)),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_id_r, out_status_r};
  assign out_tuser  = out_exp_r;
  assign out_tlast  = out_last_r;

endmodule

### src/stt_checker.sv
// port-level checks for the soft timer table, bound to the top level
`timescale 1ns / 1ps

module stt_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tuser,
  input logic       out_tlast
);

  // a stalled result beat holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser)
      && $stable(out_tlast))
    else $error("stalled result beat changed");

  // one item at a time: no beat taken right after one was accepted
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("action beat accepted while busy");

  // an expiry never reports a failure
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> !out_tdata[0])
    else $error("expiry beat with failed status");

  // only expiry beats can be non-final
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tuser)
    else $error("non-final beat that is not an expiry");

endmodule

bind soft_timer_table stt_checker u_stt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

### sim/tb_soft_timer_table.sv
// self-checking testbench for the soft timer table: stream driver, result monitor, slot predictor
`timescale 1ns / 1ps

module tb_soft_timer_table;
  import stt_pkg::*;

  localparam int NUM_SLOTS   = NUM_SLOTS_DEF;
  localparam int CYCLE_LIMIT = 400000;
  // a scanning tick walks every slot once; the settle time covers that walk with margin
  localparam int SETTLE_CYCLES = NUM_SLOTS + 8;

  // one action beat as queued for the driver
  typedef struct {
    logic [2:0]  action;
    logic [3:0]  slot;
    logic [15:0] timeout;
    logic        single_mode;
    logic        notify;
    bit          drain_first;  // hold this beat until every result is back
  } timer_action_t;

  // one result beat as predicted
  typedef struct packed {
    logic       status;
    logic [3:0] id;
    logic       expired;
    logic       last;
  } timer_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tuser;
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = '0;

  soft_timer_table #(
    .NUM_SLOTS(NUM_SLOTS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // timer table predictor: own copy of slots, prescaler and scan period
  // ---------------------------------------------------------------------------
  logic        tm_valid     [NUM_SLOTS];
  logic        tm_enabled   [NUM_SLOTS];
  logic        tm_single    [NUM_SLOTS];
  logic        tm_notify    [NUM_SLOTS];
  logic [15:0] tm_remaining [NUM_SLOTS];
  logic [15:0] tm_period    [NUM_SLOTS];
  logic [4:0]  tm_in_use;
  logic [7:0]  tm_prescale;
  logic [7:0]  tm_scan_period;

  timer_result_t expected_results[$];
  timer_action_t pending_actions[$];
  logic [3:0]    fired_slots[$];

  int errors = 0;
  int queued_count = 0;
  int accepted_count = 0;
  bit calm = 1'b0;  // no idling on either side in the closing part

  function automatic void clear_table();
    for (int s = 0; s < NUM_SLOTS; s++) begin
      tm_valid[s]     = 1'b0;
      tm_enabled[s]   = 1'b0;
      tm_single[s]    = 1'b0;
      tm_notify[s]    = 1'b0;
      tm_remaining[s] = '0;
      tm_period[s]    = '0;
    end
    tm_in_use      = '0;
    tm_scan_period = SCAN_PERIOD_RESET;
    tm_prescale    = SCAN_PERIOD_RESET;
  endfunction

  function automatic void push_result(logic status, logic [3:0] id, logic expired,
                                      logic last);
    timer_result_t r;
    r.status  = status;
    r.id      = id;
    r.expired = expired;
    r.last    = last;
    expected_results.push_back(r);
  endfunction

  // one pass over the table, collecting notifying slots that hit zero
  function automatic void scan_table();
    fired_slots.delete();
    for (int s = 0; s < NUM_SLOTS; s++) begin
      if (tm_valid[s] && tm_enabled[s]) begin
        tm_remaining[s] = tm_remaining[s] - 16'd1;
        if (tm_remaining[s] == 16'd0) begin
          if (tm_notify[s]) fired_slots.push_back(4'(s));
          if (tm_single[s]) tm_enabled[s] = 1'b0;
          else              tm_remaining[s] = tm_period[s];
        end
      end
    end
  endfunction

  function automatic void apply_action(timer_action_t a);
    bit placed;
    int id;
    placed = 1'b0;
    id = int'(a.slot);
    case (a.action)
      ACT_ADD: begin
        if (tm_in_use < NUM_SLOTS) begin
          for (int s = 0; s < NUM_SLOTS; s++) begin
            if (!placed && !tm_valid[s]) begin
              tm_valid[s]     = 1'b1;
              tm_enabled[s]   = 1'b0;
              tm_single[s]    = a.single_mode;
              tm_notify[s]    = a.notify;
              tm_remaining[s] = a.timeout;
              tm_period[s]    = a.timeout;
              tm_in_use       = tm_in_use + 5'd1;
              push_result(STATUS_OK, 4'(s), 1'b0, 1'b1);
              placed = 1'b1;
            end
          end
        end
        if (!placed) push_result(STATUS_FAIL, 4'd0, 1'b0, 1'b1);
      end
      ACT_DELETE: begin
        // deleting a free slot fails
        if (id >= NUM_SLOTS || !tm_valid[id] || tm_in_use == 5'd0) begin
          push_result(STATUS_FAIL, 4'd0, 1'b0, 1'b1);
        end else begin
          tm_valid[id] = 1'b0;
          tm_in_use    = tm_in_use - 5'd1;
          push_result(STATUS_OK, 4'd0, 1'b0, 1'b1);
        end
      end
      ACT_ENABLE, ACT_DISABLE, ACT_ONESHOT: begin
        if (id >= NUM_SLOTS || !tm_valid[id]) begin
          push_result(STATUS_FAIL, 4'd0, 1'b0, 1'b1);
        end else begin
          if (a.action == ACT_ENABLE) begin
            tm_enabled[id]   = 1'b1;
            tm_remaining[id] = a.timeout;
            tm_period[id]    = a.timeout;
          end else if (a.action == ACT_DISABLE) begin
            tm_enabled[id] = 1'b0;
          end else begin
            tm_single[id] = a.single_mode;
          end
          push_result(STATUS_OK, 4'd0, 1'b0, 1'b1);
        end
      end
      ACT_TICK: begin
        fired_slots.delete();
        if (tm_prescale != 8'd0) tm_prescale = tm_prescale - 8'd1;
        if (tm_prescale == 8'd0) begin
          tm_prescale = tm_scan_period;
          scan_table();
        end
        if (fired_slots.size() == 0) begin
          push_result(STATUS_OK, 4'd0, 1'b0, 1'b1);
        end else begin
          for (int k = 0; k < fired_slots.size(); k++)
            push_result(STATUS_OK, fired_slots[k], 1'b1, k == fired_slots.size() - 1);
        end
      end
      default: push_result(STATUS_FAIL, 4'd0, 1'b0, 1'b1);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // action stream driver
  // ---------------------------------------------------------------------------
  timer_action_t in_flight;
  int in_gap = 0;

  always @(posedge clk) begin : drive_actions
    bit free;
    timer_action_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      free = !in_tvalid;
      if (in_tvalid && in_tready) begin
        // beat taken at this edge: predict before counting it
        apply_action(in_flight);
        accepted_count++;
        free = 1'b1;
        if (!calm && $urandom_range(0, 4) == 0) in_gap = $urandom_range(1, 6);
      end
      if (free) begin
        if (in_gap > 0) begin
          in_gap--;
          in_tvalid <= 1'b0;
        end else if (pending_actions.size() > 0 &&
                     !(pending_actions[0].drain_first && expected_results.size() > 0)) begin
          nxt = pending_actions.pop_front();
          in_flight = nxt;
          in_tdata  <= {2'b00, nxt.notify, nxt.single_mode, nxt.timeout, nxt.slot};
          in_tuser  <= nxt.action;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result side: random back-pressure and field-by-field check
  // ---------------------------------------------------------------------------
  int out_stall = 0;

  always @(posedge clk) begin : drive_ready
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (calm) begin
      out_tready <= 1'b1;
    end else if (out_stall > 0) begin
      out_stall--;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      out_stall = $urandom_range(1, 6) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    timer_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        $error("result beat with nothing expected: tdata %h tuser %b tlast %b",
               out_tdata, out_tuser, out_tlast);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (out_tdata[0] !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_tdata[0]);
          errors++;
        end
        if (out_tdata[4:1] !== want.id) begin
          $error("result_id: expected %0d, got %0d", want.id, out_tdata[4:1]);
          errors++;
        end
        if (out_tuser !== want.expired) begin
          $error("expired: expected %0d, got %0d", want.expired, out_tuser);
          errors++;
        end
        if (out_tlast !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_tlast);
          errors++;
        end
        if (out_tdata[7:5] !== 3'b000) begin
          $error("pad: expected 0, got %0d", out_tdata[7:5]);
          errors++;
        end
      end
    end
  end

  // run limit
  int cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  task automatic push_action(logic [2:0] action, logic [3:0] slot, logic [15:0] timeout,
                             logic single_mode, logic notify, bit drain_first = 1'b0);
    timer_action_t a;
    a.action      = action;
    a.slot        = slot;
    a.timeout     = timeout;
    a.single_mode = single_mode;
    a.notify      = notify;
    a.drain_first = drain_first;
    pending_actions.push_back(a);
    queued_count++;
  endtask

  // mostly short counts so slots expire, with extremes and full-width values mixed in
  function automatic logic [15:0] pick_timeout();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 16'($urandom_range(0, 4));
    if (r < 85) return 16'($urandom);
    case ($urandom_range(0, 3))
      0:       return 16'd0;
      1:       return 16'd1;
      2:       return 16'hFFFE;
      default: return 16'hFFFF;
    endcase
  endfunction

  // low slots are the ones most likely in use
  function automatic logic [3:0] pick_slot();
    if ($urandom_range(0, 1) == 0) return 4'($urandom_range(0, 3));
    return 4'($urandom_range(0, 15));
  endfunction

  task automatic tick_once();
    push_action(ACT_TICK, 4'($urandom), 16'($urandom), 1'($urandom), 1'($urandom));
  endtask

  task automatic queue_random(int n);
    int added;
    int r;
    logic [2:0] act;
    added = 0;
    while (added < n) begin
      r = $urandom_range(0, 99);
      if (r < 6) begin
        // try to fill the table, last one or more add into a full table
        for (int k = 0; k < NUM_SLOTS + 1; k++)
          push_action(ACT_ADD, 4'($urandom), pick_timeout(), 1'($urandom), 1'($urandom));
        added += NUM_SLOTS + 1;
      end else if (r < 55) begin
        // sometimes free a slot, then claim one, arm it, then let time pass
        if ($urandom_range(0, 2) == 0) begin
          push_action(ACT_DELETE, pick_slot(), 16'($urandom), 1'($urandom), 1'($urandom));
          added++;
        end
        push_action(ACT_ADD, 4'($urandom), pick_timeout(), 1'($urandom),
                    $urandom_range(0, 3) != 0);
        push_action(ACT_ENABLE, pick_slot(), pick_timeout(), 1'($urandom), 1'($urandom));
        added += 2;
        if ($urandom_range(0, 3) == 0) begin
          push_action(ACT_ONESHOT, pick_slot(), 16'($urandom), 1'($urandom), 1'($urandom));
          added++;
        end
        for (int k = $urandom_range(1, 4); k > 0; k--) begin
          tick_once();
          added++;
        end
      end else begin
        // single noise beat, ticks weighted up, unknown codes included
        r = $urandom_range(0, 19);
        if (r < 8)       act = ACT_TICK;
        else if (r < 18) act = 3'($urandom_range(0, 4));
        else             act = 3'($urandom_range(6, 7));
        push_action(act, pick_slot(), pick_timeout(), 1'($urandom), 1'($urandom),
                    $urandom_range(0, 39) == 0);
        added++;
      end
    end
  endtask

  // block is idle once every beat is in and every result is out
  task automatic wait_idle();
    while (!(accepted_count == queued_count && expected_results.size() == 0))
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_scan_period(logic [7:0] value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    tm_scan_period = value;
  endtask

  initial begin
    clear_table();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed part, reset scan period
    push_action(ACT_ADD, 4'd0, 16'd0, 1'b0, 1'b1);        // periodic, zero period
    push_action(ACT_ADD, 4'd0, 16'hFFFF, 1'b1, 1'b1);     // one-shot, max count
    push_action(ACT_ADD, 4'd0, 16'd1, 1'b0, 1'b0);        // silent slot
    push_action(ACT_ENABLE, 4'd0, 16'd0, 1'b0, 1'b0);     // zero timeout wraps on scan
    push_action(ACT_ENABLE, 4'd1, 16'd2, 1'b0, 1'b0);
    push_action(ACT_ENABLE, 4'd2, 16'd1, 1'b0, 1'b0);
    push_action(ACT_ONESHOT, 4'd2, 16'd0, 1'b1, 1'b0);
    push_action(ACT_DISABLE, 4'd3, 16'd0, 1'b0, 1'b0);    // free slot
    push_action(ACT_DELETE, 4'd15, 16'd0, 1'b0, 1'b0);    // free slot
    push_action(ACT_ENABLE, 4'd9, 16'hFFFF, 1'b1, 1'b1);  // free slot
    push_action(ACT_ONESHOT, 4'd9, 16'd0, 1'b1, 1'b0);    // free slot
    push_action(3'd6, 4'd15, 16'hFFFF, 1'b1, 1'b1);       // unknown action
    push_action(3'd7, 4'd0, 16'd0, 1'b0, 1'b0);          // unknown action
    push_action(ACT_DELETE, 4'd2, 16'd0, 1'b0, 1'b0);
    push_action(ACT_DELETE, 4'd2, 16'd0, 1'b0, 1'b0);     // already deleted
    push_action(ACT_ADD, 4'd15, 16'd3, 1'b1, 1'b1);       // reuses slot 2
    push_action(ACT_ENABLE, 4'd2, 16'd3, 1'b0, 1'b0);
    push_action(ACT_TICK, 4'd15, 16'hFFFF, 1'b1, 1'b1);   // prescaler only

    // scan period of one, taking effect at the next prescaler reload
    write_scan_period(8'd1);
    for (int k = 0; k < 4; k++) tick_once();

    // zero scan period, taking effect at the next prescaler reload
    write_scan_period(8'd0);
    tick_once();
    tick_once();

    // random part across several scan periods
    write_scan_period(8'd1);
    push_action(ACT_TICK, 4'd0, 16'd0, 1'b0, 1'b0, 1'b1);
    queue_random(130);

    write_scan_period(8'd255);
    queue_random(50);

    // every slot expiring in the same scan, then random
    write_scan_period(8'd0);
    for (int s = 0; s < NUM_SLOTS; s++)
      push_action(ACT_DELETE, 4'(s), 16'($urandom), 1'($urandom), 1'($urandom));
    for (int s = 0; s < NUM_SLOTS; s++)
      push_action(ACT_ADD, 4'($urandom), 16'd1, 1'b0, 1'b1);
    for (int s = 0; s < NUM_SLOTS; s++)
      push_action(ACT_ENABLE, 4'(s), 16'd1, 1'($urandom), 1'($urandom));
    for (int k = 0; k < 3; k++) tick_once();
    queue_random(40);

    write_scan_period(8'd3);
    queue_random(30);

    // closing part without idling
    write_scan_period(8'd2);
    calm = 1'b1;
    queue_random(110);

    wait_idle();
    if (errors == 0 && expected_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
